[rtl/rss_pkg.sv]
`timescale 1ns / 1ps

package rss_pkg;

    localparam int COORD_BITS  = 16;
    localparam int NPIECE      = 4;
    localparam int IN_W        = 8 * COORD_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 4 * COORD_BITS;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int QDEPTH      = 2;
    localparam int QAW         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW         = $clog2(QDEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [COORD_BITS:0]   t_ext;

    typedef struct packed {
        t_coord l;
        t_coord t;
        t_coord r;
        t_coord b;
    } t_box;

    // one classified item: candidate pieces, which of them survive, empty marker
    typedef struct packed {
        t_box [NPIECE-1:0]  pc;
        logic [NPIECE-1:0]  mask;
        logic               empty;
    } t_job;

    function automatic t_ext ext(input t_coord x);
        return t_ext'({x[COORD_BITS-1], x});
    endfunction

endpackage

[rtl/rss_front.sv]
`timescale 1ns / 1ps

module rss_front
    import rss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // base_left, base_top, base_right, base_bottom, cut_left, cut_top, cut_right, cut_bottom
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                  o_wr_valid,
    input  logic                  i_wr_ready,
    output t_job                  o_wr_job
);

    t_box  in_base;
    t_box  in_cut;
    t_box  n_clip;
    logic  n_ovl;

    logic  r_v;
    t_box  r_base;
    t_box  r_clip;
    logic  r_ovl;

    t_ext  pl [NPIECE];
    t_ext  pt [NPIECE];
    t_ext  pr [NPIECE];
    t_ext  pb [NPIECE];
    logic [NPIECE-1:0] keep;

    always_comb begin
        in_base.l = t_coord'(s_axis_tdata[0*COORD_BITS +: COORD_BITS]);
        in_base.t = t_coord'(s_axis_tdata[1*COORD_BITS +: COORD_BITS]);
        in_base.r = t_coord'(s_axis_tdata[2*COORD_BITS +: COORD_BITS]);
        in_base.b = t_coord'(s_axis_tdata[3*COORD_BITS +: COORD_BITS]);
        in_cut.l  = t_coord'(s_axis_tdata[4*COORD_BITS +: COORD_BITS]);
        in_cut.t  = t_coord'(s_axis_tdata[5*COORD_BITS +: COORD_BITS]);
        in_cut.r  = t_coord'(s_axis_tdata[6*COORD_BITS +: COORD_BITS]);
        in_cut.b  = t_coord'(s_axis_tdata[7*COORD_BITS +: COORD_BITS]);

        n_ovl = (in_cut.l <= in_base.r) && (in_base.l <= in_cut.r) &&
                (in_base.b >= in_cut.t) && (in_base.t <= in_cut.b);

        n_clip.l = (in_base.l > in_cut.l) ? in_base.l : in_cut.l;
        n_clip.t = (in_base.t > in_cut.t) ? in_base.t : in_cut.t;
        n_clip.r = (in_base.r < in_cut.r) ? in_base.r : in_cut.r;
        n_clip.b = (in_base.b < in_cut.b) ? in_base.b : in_cut.b;
    end

    assign s_axis_tready = !r_v || i_wr_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (s_axis_tready) begin
            r_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_base <= in_base;
            r_clip <= n_clip;
            r_ovl  <= n_ovl;
        end
    end

    // band above, middle left, middle right, band below, one bit wider
    always_comb begin
        pl[0] = ext(r_base.l);             pt[0] = ext(r_base.t);
        pr[0] = ext(r_base.r);             pb[0] = ext(r_clip.t) - t_ext'(1);
        pl[1] = ext(r_base.l);             pt[1] = ext(r_clip.t);
        pr[1] = ext(r_clip.l) - t_ext'(1); pb[1] = ext(r_clip.b);
        pl[2] = ext(r_clip.r) + t_ext'(1); pt[2] = ext(r_clip.t);
        pr[2] = ext(r_base.r);             pb[2] = ext(r_clip.b);
        pl[3] = ext(r_base.l);             pt[3] = ext(r_clip.b) + t_ext'(1);
        pr[3] = ext(r_base.r);             pb[3] = ext(r_base.b);

        for (int k = 0; k < NPIECE; k++) begin
            keep[k] = (pl[k] <= pr[k]) && (pt[k] <= pb[k]);
        end

        o_wr_job = '0;
        if (!r_ovl) begin
            o_wr_job.pc[0] = r_base;
            o_wr_job.mask  = NPIECE'(1);
        end else if (keep == '0) begin
            o_wr_job.mask  = NPIECE'(1);
            o_wr_job.empty = 1'b1;
        end else begin
            for (int k = 0; k < NPIECE; k++) begin
                o_wr_job.pc[k].l = pl[k][COORD_BITS-1:0];
                o_wr_job.pc[k].t = pt[k][COORD_BITS-1:0];
                o_wr_job.pc[k].r = pr[k][COORD_BITS-1:0];
                o_wr_job.pc[k].b = pb[k][COORD_BITS-1:0];
            end
            o_wr_job.mask = keep;
        end
    end

    assign o_wr_valid = r_v;

endmodule

[rtl/rss_queue.sv]
`timescale 1ns / 1ps

module rss_queue
    import rss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_job i_wr_job,
    output logic o_rd_valid,
    input  logic i_rd_pop,
    output t_job o_rd_job
);

    t_job            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QCW-1:0]  r_cnt;
    logic            push;
    logic            pop;

    assign o_wr_ready = (r_cnt != QCW'(QDEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_job   = r_mem[r_rp];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = i_rd_pop && o_rd_valid;

    function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
        return (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= bump(r_wp);
            end
            if (pop) begin
                r_rp <= bump(r_rp);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_wr_job;
        end
    end

endmodule

[rtl/rss_back.sv]
`timescale 1ns / 1ps

module rss_back
    import rss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_valid,
    output logic                   o_rd_pop,
    input  t_job                   i_rd_job,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // piece_left, piece_top, piece_right, piece_bottom
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // nothing_left
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic              r_busy;
    t_job              r_job;
    logic              r_m_valid;
    t_box              r_box;
    logic              r_empty;
    logic              r_last;

    t_job              cur;
    t_job              n_job;
    logic              have;
    logic              slot_free;
    logic              fire;
    logic [NPIECE-1:0] low;
    logic [NPIECE-1:0] rest;
    t_box              sel;

    assign cur       = r_busy ? r_job : i_rd_job;
    assign have      = r_busy || i_rd_valid;
    assign slot_free = !r_m_valid || m_axis_tready;
    assign fire      = have && slot_free;
    assign o_rd_pop  = fire && !r_busy;

    // lowest surviving piece goes next
    always_comb begin
        low = cur.mask & (~cur.mask + NPIECE'(1));
        sel = cur.pc[0];
        for (int k = NPIECE - 1; k >= 0; k--) begin
            if (low[k]) begin
                sel = cur.pc[k];
            end
        end
        rest = cur.mask & ~low;
        n_job = cur;
        n_job.mask = rest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_busy    <= (rest != '0);
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_job      <= n_job;
            r_box      <= sel;
            r_empty    <= cur.empty;
            r_last     <= (rest == '0);
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[0*COORD_BITS +: COORD_BITS] = r_box.l;
        m_axis_tdata[1*COORD_BITS +: COORD_BITS] = r_box.t;
        m_axis_tdata[2*COORD_BITS +: COORD_BITS] = r_box.r;
        m_axis_tdata[3*COORD_BITS +: COORD_BITS] = r_box.b;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_empty;
    assign m_axis_tlast  = r_last;

endmodule

[rtl/rectangle_subtract_split_core.sv]
`timescale 1ns / 1ps

// Subtracts a cutting rectangle from a base rectangle (inclusive signed edges) and
// streams out what is left: the base whole if the two do not overlap, else up to four
// pieces in the order band above, middle left, middle right, band below, with tlast on
// the final word of each item; when the cutter covers the base, one word with tuser set
// and zero edges. The output stage sends one piece a cycle while m_axis_tready allows,
// so an item yields one to four words; the front takes an item every
// cycle while the two-entry queue has room. From input to first word an item passes
// the input register, the queue and the output register.

module rectangle_subtract_split_core
    import rss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // base_left, base_top, base_right, base_bottom, cut_left, cut_top, cut_right, cut_bottom
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // piece_left, piece_top, piece_right, piece_bottom
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // nothing_left
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic wr_valid;
    logic wr_ready;
    t_job wr_job;
    logic rd_valid;
    logic rd_pop;
    t_job rd_job;

    rss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_wr_valid    (wr_valid),
        .i_wr_ready    (wr_ready),
        .o_wr_job      (wr_job)
    );

    rss_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (wr_valid),
        .o_wr_ready (wr_ready),
        .i_wr_job   (wr_job),
        .o_rd_valid (rd_valid),
        .i_rd_pop   (rd_pop),
        .o_rd_job   (rd_job)
    );

    rss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_valid    (rd_valid),
        .o_rd_pop      (rd_pop),
        .i_rd_job      (rd_job),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[sim/rectangle_subtract_split_core_tb.sv]
`timescale 1ns / 1ps

module rectangle_subtract_split_core_tb;
    import rss_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_ITEMS  = 90;
    localparam int SETTLE_WAIT  = 20;

    typedef struct packed {
        t_box base;
        t_box cut;
    } t_rect_pair;

    typedef struct packed {
        t_box box;
        logic empty;
        logic last;
    } t_piece;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // base_left, base_top, base_right, base_bottom, cut_left, cut_top, cut_right, cut_bottom
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // piece_left, piece_top, piece_right, piece_bottom
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // nothing_left
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    t_rect_pair pending_pairs[$];
    t_piece     expected_pieces[$];

    logic in_taken = 1'b0;
    logic rx_hold = 1'b0;
    logic hold_go = 1'b0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    int   n_queued = 0;
    int   n_accepted = 0;
    int   n_pieces = 0;
    int   n_covered = 0;
    int   n_untouched = 0;
    int   n_errors = 0;
    int   quiet_cycles = 0;

    rectangle_subtract_split_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic t_coord clamp_coord(input int v);
        if (v > 32767) begin
            return t_coord'(32767);
        end
        if (v < -32768) begin
            return t_coord'(-32768);
        end
        return t_coord'(v);
    endfunction

    // spans spread over every power of two so both tiny and huge rectangles turn up
    function automatic int pick_span();
        return int'($urandom_range(0, (1 << $urandom_range(0, 16)) - 1));
    endfunction

    // works out the remaining pieces of one word and queues them in output order
    function automatic void subtract_rect(input t_rect_pair p);
        int     bl, bt, br, bb, cl, ct, cr, cb;
        int     kl, kt, kr, kb;
        int     pl[4], pt[4], pr[4], pb[4];
        logic   keep[4];
        int     n;
        int     k;
        int     idx;
        t_piece pc;
        bl = p.base.l; bt = p.base.t; br = p.base.r; bb = p.base.b;
        cl = p.cut.l;  ct = p.cut.t;  cr = p.cut.r;  cb = p.cut.b;
        pc.empty = 1'b0;
        pc.last  = 1'b1;
        if (!(cl <= br && bl <= cr && bb >= ct && bt <= cb)) begin
            pc.box = p.base;
            expected_pieces.push_back(pc);
            n_untouched++;
            return;
        end
        kl = (bl > cl) ? bl : cl;
        kr = (br < cr) ? br : cr;
        kt = (bt > ct) ? bt : ct;
        kb = (bb < cb) ? bb : cb;
        // band above, middle left, middle right, band below; int holds the extra bit
        pl[0] = bl;     pt[0] = bt;     pr[0] = br;     pb[0] = kt - 1;
        pl[1] = bl;     pt[1] = kt;     pr[1] = kl - 1; pb[1] = kb;
        pl[2] = kr + 1; pt[2] = kt;     pr[2] = br;     pb[2] = kb;
        pl[3] = bl;     pt[3] = kb + 1; pr[3] = br;     pb[3] = bb;
        n = 0;
        for (k = 0; k < 4; k++) begin
            keep[k] = (pl[k] <= pr[k]) && (pt[k] <= pb[k]);
            if (keep[k]) begin
                n++;
            end
        end
        if (n == 0) begin
            pc.box   = '0;
            pc.empty = 1'b1;
            expected_pieces.push_back(pc);
            n_covered++;
            return;
        end
        idx = 0;
        for (k = 0; k < 4; k++) begin
            if (keep[k]) begin
                idx++;
                pc.box.l = t_coord'(pl[k]);
                pc.box.t = t_coord'(pt[k]);
                pc.box.r = t_coord'(pr[k]);
                pc.box.b = t_coord'(pb[k]);
                pc.last  = (idx == n);
                expected_pieces.push_back(pc);
            end
        end
    endfunction

    function automatic t_rect_pair random_pair();
        t_rect_pair p;
        int         bl, bt, br, bb, cl, ct, cr, cb;
        int         mode;
        int         gap;
        int         corner[7];
        corner = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        mode = $urandom_range(0, 99);
        bl = int'($urandom_range(0, 65535)) - 32768;
        bt = int'($urandom_range(0, 65535)) - 32768;
        br = clamp_coord(bl + pick_span());
        bb = clamp_coord(bt + pick_span());
        if (mode < 55) begin
            // cutter near the base, often overlapping, well formed, random placement
            cl = clamp_coord(bl + int'($urandom_range(0, br - bl + 1)) - pick_span());
            ct = clamp_coord(bt + int'($urandom_range(0, bb - bt + 1)) - pick_span());
            cr = clamp_coord(cl + pick_span());
            cb = clamp_coord(ct + pick_span());
        end else if (mode < 65) begin
            // cutter swallows the base
            cl = clamp_coord(bl - pick_span());
            ct = clamp_coord(bt - pick_span());
            cr = clamp_coord(br + pick_span());
            cb = clamp_coord(bb + pick_span());
        end else if (mode < 80) begin
            // raw bits, malformed rectangles included
            bl = $signed(16'($urandom)); bt = $signed(16'($urandom));
            br = $signed(16'($urandom)); bb = $signed(16'($urandom));
            cl = $signed(16'($urandom)); ct = $signed(16'($urandom));
            cr = $signed(16'($urandom)); cb = $signed(16'($urandom));
        end else if (mode < 90) begin
            bl = corner[$urandom_range(0, 6)]; bt = corner[$urandom_range(0, 6)];
            br = corner[$urandom_range(0, 6)]; bb = corner[$urandom_range(0, 6)];
            cl = corner[$urandom_range(0, 6)]; ct = corner[$urandom_range(0, 6)];
            cr = corner[$urandom_range(0, 6)]; cb = corner[$urandom_range(0, 6)];
        end else begin
            // cutter placed off one side of the base
            gap = pick_span();
            ct = clamp_coord(bt - pick_span());
            cb = clamp_coord(bb + pick_span());
            cl = clamp_coord(bl - pick_span());
            cr = clamp_coord(br + pick_span());
            case ($urandom_range(0, 3))
                0: begin
                    cr = clamp_coord(bl - 1 - gap);
                    cl = clamp_coord(cr - pick_span());
                end
                1: begin
                    cl = clamp_coord(br + 1 + gap);
                    cr = clamp_coord(cl + pick_span());
                end
                2: begin
                    cb = clamp_coord(bt - 1 - gap);
                    ct = clamp_coord(cb - pick_span());
                end
                default: begin
                    ct = clamp_coord(bb + 1 + gap);
                    cb = clamp_coord(ct + pick_span());
                end
            endcase
        end
        p.base.l = t_coord'(bl); p.base.t = t_coord'(bt);
        p.base.r = t_coord'(br); p.base.b = t_coord'(bb);
        p.cut.l  = t_coord'(cl); p.cut.t  = t_coord'(ct);
        p.cut.r  = t_coord'(cr); p.cut.b  = t_coord'(cb);
        return p;
    endfunction

    task automatic add_pair(input int bl, input int bt, input int br, input int bb,
                            input int cl, input int ct, input int cr, input int cb);
        t_rect_pair p;
        p.base.l = t_coord'(bl); p.base.t = t_coord'(bt);
        p.base.r = t_coord'(br); p.base.b = t_coord'(bb);
        p.cut.l  = t_coord'(cl); p.cut.t  = t_coord'(ct);
        p.cut.r  = t_coord'(cr); p.cut.b  = t_coord'(cb);
        pending_pairs.push_back(p);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_pieces.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // input side: a word stays offered until taken, gaps only open between words
    always @(negedge i_clk) begin : drive_in
        t_rect_pair nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                nxt = pending_pairs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.cut.b, nxt.cut.r, nxt.cut.t, nxt.cut.l,
                                  nxt.base.b, nxt.base.r, nxt.base.t, nxt.base.l};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // long output hold, counted here so the sender keeps pushing meanwhile
    initial begin : long_hold
        int left;
        wait (hold_go);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        for (left = HOLD_CYCLES; left > 0; left--) begin
            @(negedge i_clk);
        end
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin : check_out
        t_piece     want;
        t_rect_pair got_in;
        t_box       got;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.l = m_axis_tdata[15:0];
            got.t = m_axis_tdata[31:16];
            got.r = m_axis_tdata[47:32];
            got.b = m_axis_tdata[63:48];
            if (expected_pieces.size() == 0) begin
                report_mismatch($sformatf("unexpected word l=%0d t=%0d r=%0d b=%0d",
                                          got.l, got.t, got.r, got.b));
            end else begin
                want = expected_pieces.pop_front();
                n_pieces++;
                if (got.l !== want.box.l) begin
                    report_mismatch($sformatf("piece_left got %0d expected %0d",
                                              got.l, want.box.l));
                end
                if (got.t !== want.box.t) begin
                    report_mismatch($sformatf("piece_top got %0d expected %0d",
                                              got.t, want.box.t));
                end
                if (got.r !== want.box.r) begin
                    report_mismatch($sformatf("piece_right got %0d expected %0d",
                                              got.r, want.box.r));
                end
                if (got.b !== want.box.b) begin
                    report_mismatch($sformatf("piece_bottom got %0d expected %0d",
                                              got.b, want.box.b));
                end
                if (m_axis_tuser !== want.empty) begin
                    report_mismatch($sformatf("nothing_left got %b expected %b",
                                              m_axis_tuser, want.empty));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf("last_piece got %b expected %b",
                                              m_axis_tlast, want.last));
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            got_in.base.l = s_axis_tdata[15:0];
            got_in.base.t = s_axis_tdata[31:16];
            got_in.base.r = s_axis_tdata[47:32];
            got_in.base.b = s_axis_tdata[63:48];
            got_in.cut.l  = s_axis_tdata[79:64];
            got_in.cut.t  = s_axis_tdata[95:80];
            got_in.cut.r  = s_axis_tdata[111:96];
            got_in.cut.b  = s_axis_tdata[127:112];
            subtract_rect(got_in);
            n_accepted++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int ph;
        int i;
        int tx_pct[4];
        int rx_pct[4];
        tx_pct = '{0, 45, 0, 18};
        rx_pct = '{0, 0, 45, 18};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no overlap, cutter inside, cutter covering, single bands
        add_pair(0, 0, 10, 10, 20, 0, 30, 10);
        add_pair(0, 0, 10, 10, 3, 4, 6, 7);
        add_pair(0, 0, 10, 10, -5, -5, 15, 15);
        add_pair(0, 0, 10, 10, -5, -5, 15, 4);
        add_pair(0, 0, 10, 10, -5, 6, 15, 15);
        add_pair(0, 0, 10, 10, -5, -5, 4, 15);
        add_pair(0, 0, 10, 10, 6, -5, 15, 15);
        // touching edge overlaps, adjacent misses
        add_pair(0, 0, 10, 10, 10, 10, 20, 20);
        add_pair(0, 0, 10, 10, 11, 0, 20, 10);
        add_pair(0, 0, 10, 10, 0, -9, 10, -1);
        // full coordinate range and corner points where edge+-1 leaves the range
        add_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        add_pair(-32768, -32768, 32767, 32767, 0, 0, 0, 0);
        add_pair(-32768, -32768, 32767, 32767, -32768, -32768, -32768, -32768);
        add_pair(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
        add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
        add_pair(5, 5, 5, 5, 5, 5, 5, 5);
        // malformed base, with and without overlap
        add_pair(10, 0, 5, 10, 100, 100, 200, 200);
        add_pair(10, 0, 5, 10, 0, 2, 20, 8);
        add_pair(0, 10, 10, 0, 2, 2, 8, 8);
        // malformed cutter
        add_pair(0, 0, 30, 30, 20, 10, 5, 20);
        add_pair(0, 0, 30, 30, 10, 20, 20, 5);
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            for (i = 0; i < PHASE_ITEMS; i++) begin
                pending_pairs.push_back(random_pair());
                n_queued++;
            end
            wait_drained();
        end

        // back-pressure: output held while the input keeps coming
        tx_idle_pct  = 0;
        rx_stall_pct = 10;
        hold_go      = 1'b1;
        for (i = 0; i < PHASE_ITEMS; i++) begin
            pending_pairs.push_back(random_pair());
            n_queued++;
        end
        wait_drained();

        repeat (SETTLE_WAIT) @(posedge i_clk);
        $display("covered %0d input words and %0d output words (%0d fully cut, %0d untouched)",
                 n_accepted, n_pieces, n_covered, n_untouched);
        $display("under idle, stall, combined and long output hold phases; %0d mismatches",
                 n_errors);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
